### hw/rtl/olad_pkg.sv
// Package with the word types, action and status codes, and sequencer states of the ordered list.
package olad_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_DELETE  = 2'd1,
        ACT_DISPLAY = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DELETED  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_ENTRY    = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_SHIFT,
        S_FINISH,
        S_DISP
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] entry_value;
        logic               last;
    } t_out_word;

endpackage

### hw/rtl/ordered_list_append_delete_top.sv
// Top level of the ordered list: entry memory, read-modify-write sequencer and output register.
//
// This block keeps up to LIST_DEPTH signed 32-bit values in insertion order in one
// synchronous memory with a single registered read port and one write port. An insert
// word appends at the tail (status inserted) or, when the list is full, is dropped with
// status full. A delete word scans from the head, removes the first equal entry and moves
// every later entry one place toward the head (status deleted), or reports not found.
// A display word returns every entry from head to tail with status entry, the last one
// marked; an empty list returns one word with status empty and value zero. Action code 3
// is ignored and returns nothing. Every request returns at least one word except that one,
// and the final word of a request has last set. One request is handled at a time: the
// input is ready only while the sequencer is idle, but a finished word may still sit in
// the output register while the next request is taken. A delete streams the entries
// through the single memory read port one entry per cycle, first through the compare and
// then through the shift that closes the gap; display also reads one entry per cycle
// through that port while the output is not stalled. A stalled output pauses display and
// replays the pending read.
module ordered_list_append_delete_top #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  olad_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output olad_pkg::t_out_word o_data
);
    import olad_pkg::*;

    // Index width for the memory, and count width that can hold LIST_DEPTH itself.
    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic signed [31:0] mem [LIST_DEPTH];

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_ra, n_ra;
    logic               r_pv, n_pv;
    logic [AW-1:0]      r_pi, n_pi;
    logic signed [31:0] r_value, n_value;
    t_status            r_res_status, n_res_status;
    logic               r_ov, n_ov;
    t_out_word          r_out, n_out;
    logic signed [31:0] r_rdata;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               out_free;
    logic [CW-1:0]      iss_addr;

    // Entry memory. Reads always run ahead of writes during the shift, so the write
    // address is always below the read address and no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra         <= n_ra;
        r_pi         <= n_pi;
        r_value      <= n_value;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ra         = r_ra;
        n_pv         = 1'b0;
        n_pi         = r_pi;
        n_value      = r_value;
        n_res_status = r_res_status;
        out_free     = !r_ov || i_ready;
        n_ov         = r_ov && !i_ready;
        n_out        = r_out;
        rd_en        = 1'b0;
        rd_addr      = r_ra[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_count[AW-1:0];
        wr_data      = r_value;
        iss_addr     = r_ra;
        o_ready      = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ra    = '0;
                    n_value = i_data.value;
                    case (i_data.action)
                        ACT_INSERT:  n_state = S_INSERT;
                        ACT_DELETE:  n_state = S_SCAN;
                        ACT_DISPLAY: n_state = S_DISP;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end

            S_INSERT: begin
                if (out_free) begin
                    if (r_count == CW'(LIST_DEPTH)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        wr_en        = 1'b1;
                        n_count      = r_count + 1'b1;
                        n_out.status = ST_INSERTED;
                    end
                    n_out.entry_value = r_value;
                    n_out.last        = 1'b1;
                    n_ov              = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            S_SCAN, S_SHIFT: begin
                // Stream one read per cycle over the valid entries.
                if (r_ra < r_count) begin
                    rd_en   = 1'b1;
                    n_ra    = r_ra + 1'b1;
                    n_pv    = 1'b1;
                    n_pi    = r_ra[AW-1:0];
                end
                if (r_state == S_SCAN) begin
                    if (r_pv && (r_rdata == r_value)) begin
                        n_state = S_SHIFT;
                    end else if (!r_pv && (r_ra >= r_count)) begin
                        n_res_status = ST_NOTFOUND;
                        n_state      = S_FINISH;
                    end
                end else begin
                    // Each entry after the match moves one place toward the head.
                    if (r_pv) begin
                        wr_en   = 1'b1;
                        wr_addr = r_pi - 1'b1;
                        wr_data = r_rdata;
                    end else if (r_ra >= r_count) begin
                        n_count      = r_count - 1'b1;
                        n_res_status = ST_DELETED;
                        n_state      = S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    n_out.status      = r_res_status;
                    n_out.entry_value = r_value;
                    n_out.last        = 1'b1;
                    n_ov              = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            S_DISP: begin
                if (r_count == '0) begin
                    if (out_free) begin
                        n_out.status      = ST_EMPTY;
                        n_out.entry_value = '0;
                        n_out.last        = 1'b1;
                        n_ov              = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    // On a stalled output the pending entry is read again.
                    iss_addr = (r_pv && !out_free) ? CW'(r_pi) : r_ra;
                    if (iss_addr < r_count) begin
                        rd_en   = 1'b1;
                        rd_addr = iss_addr[AW-1:0];
                        n_ra    = iss_addr + 1'b1;
                        n_pv    = 1'b1;
                        n_pi    = iss_addr[AW-1:0];
                    end
                    if (r_pv && out_free) begin
                        n_out.status      = ST_ENTRY;
                        n_out.entry_value = r_rdata;
                        n_out.last        = ((CW'(r_pi) + 1'b1) == r_count);
                        n_ov              = 1'b1;
                        if ((CW'(r_pi) + 1'b1) == r_count) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("entry count exceeds list depth");

    // A write never lands on the entry being read in the same cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("memory write and read hit the same entry");

    // During the shift, the returned entry always lies after the head.
    a_shift_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pv) |-> (r_pi != '0))
        else $error("shift returned the head entry");

    // A delete that completes removes exactly one entry.
    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && n_state == S_FINISH) |=> (r_count == $past(r_count) - 1'b1))
        else $error("delete did not reduce the count by one");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for the ordered list: random traffic, a list predictor and a word checker.
module tb_top;

    import olad_pkg::*;

    localparam int LIST_DEPTH     = 16;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 245;
    localparam int IDLE_PERCENT   = 26;
    localparam int MAX_REPORTS    = 10;
    // Requests accepted before the receiver's long hold-off begins, and how long it lasts.
    localparam int HOLD_AT        = 12;
    localparam int HOLD_CYCLES    = 200;
    // Window of accepted requests during which neither side idles.
    localparam int CALM_FROM      = 150;
    localparam int CALM_TO        = 200;
    // A delete streams the whole list through the scan and the shift, so the settle time scales with the depth.
    localparam int SETTLE_CYCLES  = 2 * LIST_DEPTH + 8;
    localparam int TIMEOUT_CYCLES = 600_000;

    // Action code 3 has no member in the package enum; the block must ignore it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        t_in_word word;
        bit       drain_first;
    } t_stim_item;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_data;

    // Requests waiting to be offered, filled once by the stimulus block below.
    t_stim_item request_queue[$];
    // Contents the stimulus generator expects the list to hold, used to pick deletes that hit.
    logic signed [31:0] planned_list[$];
    logic signed [31:0] value_pool[8];
    int n_planned = 0;

    // Predictor state: the list as the block should hold it after every accepted request.
    logic signed [31:0] list_model[$];
    // Result words still owed by the block, oldest first.
    t_out_word due_words[$];

    int n_sent      = 0;
    int n_predicted = 0;
    int n_checked   = 0;
    int n_failures  = 0;

    int   hold_left = 0;
    bit   hold_done = 1'b0;
    logic hold_active;
    logic calm;

    assign hold_active = (hold_left != 0);
    assign calm        = (n_sent >= CALM_FROM) && (n_sent < CALM_TO);

    ordered_list_append_delete_top #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Appends one owed result word to the tail of the expectation store.
    function automatic void owe_word(t_status status, logic signed [31:0] value, logic last);
        t_out_word w;
        w.status      = status;
        w.entry_value = value;
        w.last        = last;
        due_words.push_back(w);
        n_predicted++;
    endfunction

    // Applies one accepted request to the list model and records the words it must produce.
    function automatic void compute_list_responses(t_in_word req);
        int hit;
        hit = -1;
        case (req.action)
            ACT_INSERT: begin
                if (list_model.size() >= LIST_DEPTH) begin
                    owe_word(ST_FULL, req.value, 1'b1);
                end else begin
                    list_model.push_back(req.value);
                    owe_word(ST_INSERTED, req.value, 1'b1);
                end
            end
            ACT_DELETE: begin
                // Values match as raw 32-bit patterns; only the first match from the head goes.
                for (int i = 0; i < list_model.size(); i++) begin
                    if (hit < 0 && list_model[i] == req.value) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    list_model.delete(hit);
                    owe_word(ST_DELETED, req.value, 1'b1);
                end else begin
                    owe_word(ST_NOTFOUND, req.value, 1'b1);
                end
            end
            ACT_DISPLAY: begin
                if (list_model.size() == 0) begin
                    owe_word(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < list_model.size(); i++) begin
                        owe_word(ST_ENTRY, list_model[i], (i == list_model.size() - 1));
                    end
                end
            end
            default: begin
                // The unused code leaves the list alone and produces nothing.
            end
        endcase
    endfunction

    // Counts a failure and prints it while the report budget lasts.
    function automatic void log_failure(string msg);
        n_failures++;
        if (n_failures <= MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // Queues one request and tracks what the list will hold so later deletes can aim at it.
    task automatic add_request(logic [1:0] act, logic signed [31:0] val, bit drain);
        t_stim_item item;
        int hit;
        item.word.action = act;
        item.word.value  = val;
        item.drain_first = drain;
        request_queue.push_back(item);
        hit = -1;
        if (act != ACT_UNUSED) begin
            n_planned++;
        end
        if (act == ACT_INSERT && planned_list.size() < LIST_DEPTH) begin
            planned_list.push_back(val);
        end else if (act == ACT_DELETE) begin
            for (int i = 0; i < planned_list.size(); i++) begin
                if (hit < 0 && planned_list[i] == val) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                planned_list.delete(hit);
            end
        end
    endtask

    // Mixes wide random values with a small pool and with values already in the list,
    // so that duplicates and delete hits are common.
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 3);
        if (r == 2) begin
            return value_pool[$urandom_range(0, 7)];
        end
        if (r == 3 && planned_list.size() != 0) begin
            return planned_list[$urandom_range(0, planned_list.size() - 1)];
        end
        return $urandom;
    endfunction

    // Sender. A word is accepted when i_valid and o_ready are both high at the edge; the
    // predictor runs right there. Valid then stays low unless the next word is offered at
    // once, and a held word never changes until it is taken.
    always @(posedge i_clk) begin
        logic       next_valid;
        t_in_word   next_data;
        t_stim_item item;
        next_valid = i_valid;
        next_data  = i_data;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                compute_list_responses(i_data);
                n_sent <= n_sent + 1;
                next_valid = 1'b0;
            end
            if (!next_valid && request_queue.size() != 0) begin
                // A drain marker holds the sender until every owed word has been checked.
                if (request_queue[0].drain_first && n_checked < n_predicted) begin
                    next_valid = 1'b0;
                end else if (calm || $urandom_range(0, 99) >= IDLE_PERCENT) begin
                    item       = request_queue.pop_front();
                    next_valid = 1'b1;
                    next_data  = item.word;
                end
            end
        end
        i_valid <= next_valid;
        i_data  <= next_data;
    end

    // Receiver hold-off: once a dozen requests are in, the receiver refuses words for a long
    // stretch while the sender keeps offering, so the output register fills and the block
    // stops taking requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver and checker. Every accepted result word is compared field by field with the
    // oldest owed word; a word that nobody owes is a failure of its own.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_checked <= n_checked + 1;
                if (due_words.size() == 0) begin
                    log_failure($sformatf("unexpected word: status %0d value %0d last %0b",
                                          o_data.status, o_data.entry_value, o_data.last));
                end else begin
                    want = due_words.pop_front();
                    if (o_data.status !== want.status
                            || o_data.entry_value !== want.entry_value
                            || o_data.last !== want.last) begin
                        log_failure($sformatf(
                            {"word %0d: expected status %0d value %0d last %0b, ",
                             "got status %0d value %0d last %0b"},
                            n_checked, want.status, want.entry_value, want.last,
                            o_data.status, o_data.entry_value, o_data.last));
                    end
                end
            end
            if (hold_active) begin
                i_ready <= 1'b0;
            end else if (calm) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        int kind;
        int r;
        int span;

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < 8; i++) begin
            value_pool[i] = $urandom;
        end

        // Directed part. An empty list is displayed and searched, and the unused code is
        // sent. The list is then filled with the extremes, zero, minus one and a duplicate
        // zero plus random values, until an insert finds it full. After a pause that drains
        // every owed word, the full list is displayed, the first of two equal entries is
        // deleted, the head is deleted twice, and the dropped value is searched for.
        add_request(ACT_DISPLAY, '0, 1'b0);
        add_request(ACT_DELETE, 32'sd123, 1'b0);
        add_request(ACT_UNUSED, 32'sh5A5A_A5A5, 1'b0);
        add_request(ACT_INSERT, 32'sh8000_0000, 1'b0);
        add_request(ACT_INSERT, 32'sh7FFF_FFFF, 1'b0);
        add_request(ACT_INSERT, '0, 1'b0);
        add_request(ACT_INSERT, -32'sd1, 1'b0);
        add_request(ACT_INSERT, '0, 1'b0);
        for (int i = 0; i < LIST_DEPTH - 5; i++) begin
            add_request(ACT_INSERT, $urandom, 1'b0);
        end
        add_request(ACT_INSERT, 32'sd42, 1'b0);
        add_request(ACT_DISPLAY, '0, 1'b1);
        add_request(ACT_DELETE, '0, 1'b0);
        add_request(ACT_DELETE, 32'sh8000_0000, 1'b0);
        add_request(ACT_DELETE, 32'sh7FFF_FFFF, 1'b0);
        add_request(ACT_DELETE, 32'sd42, 1'b0);

        // Random part, built from episodes: fill runs that often reach full, drains that
        // delete entries actually present (often down to a single head entry and then to an
        // empty list), short noise runs with any action code, and pauses before a display.
        while (n_planned < 25 + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                span = $urandom_range(1, LIST_DEPTH + 2);
                for (int i = 0; i < span; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 10) begin
                        add_request(ACT_DISPLAY, $urandom, 1'b0);
                    end else begin
                        add_request(ACT_INSERT, pick_value(), 1'b0);
                    end
                end
            end else if (kind < 7) begin
                while (planned_list.size() != 0 && (kind == 4 || $urandom_range(0, 7) != 0)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        add_request(ACT_DISPLAY, $urandom, 1'b0);
                    end
                    add_request(ACT_DELETE,
                                planned_list[$urandom_range(0, planned_list.size() - 1)],
                                1'b0);
                end
                if (planned_list.size() == 0) begin
                    add_request(ACT_DELETE, pick_value(), 1'b0);
                    add_request(ACT_DISPLAY, $urandom, 1'b0);
                end
            end else if (kind < 9) begin
                span = $urandom_range(2, 8);
                for (int i = 0; i < span; i++) begin
                    add_request(2'($urandom_range(0, 3)), pick_value(), 1'b0);
                end
            end else begin
                add_request(ACT_DISPLAY, $urandom, 1'b1);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (n_checked < n_predicted) @(posedge i_clk);
        // Let any trailing activity, such as a stray word after the last one, show up.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (due_words.size() != 0) begin
            log_failure($sformatf("%0d owed words never arrived", due_words.size()));
        end
        if (n_failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
